// File: design/rai_pkg.sv
package rai_pkg;

  // default number format, signed Q16.16
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // configuration port index width
  localparam int unsigned CFG_IDX_W = 3;

  // plane axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_AXIS = 3'd0,
    REG_CORNER_X   = 3'd1,
    REG_CORNER_Y   = 3'd2,
    REG_CORNER_Z   = 3'd3,
    REG_EDGE_U     = 3'd4,
    REG_EDGE_V     = 3'd5
  } cfg_reg_e;

endpackage

// File: design/rai_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module rai_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [NW-1:0] in_num_i,
  input  logic [DW-1:0] in_den_i,
  input  logic [PW-1:0] in_pay_i,
  output logic          out_valid_o,
  output logic [NW-1:0] out_quo_o,
  output logic [PW-1:0] out_pay_o
);

  // per-stage registers; the dividend shifts out on top while quotient bits enter below
  logic          vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];
  logic [PW-1:0] pay_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          cur_vld;
    logic [DW-1:0] cur_rem;
    logic [NW-1:0] cur_nq;
    logic [DW-1:0] cur_den;
    logic [PW-1:0] cur_pay;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] nq_d;

    if (s == 0) begin : g_first
      assign cur_vld = in_valid_i;
      assign cur_rem = '0;
      assign cur_nq  = in_num_i;
      assign cur_den = in_den_i;
      assign cur_pay = in_pay_i;
    end else begin : g_next
      assign cur_vld = vld_q[s-1];
      assign cur_rem = rem_q[s-1];
      assign cur_nq  = nq_q[s-1];
      assign cur_den = den_q[s-1];
      assign cur_pay = pay_q[s-1];
    end

    // trial subtract of the divisor
    assign trial = {cur_rem, cur_nq[NW-1]};
    assign diff  = trial - {1'b0, cur_den};
    assign ge    = (trial >= {1'b0, cur_den});
    assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign nq_d  = {cur_nq[NW-2:0], ge};

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= cur_vld;
      end
    end

    // data
    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      nq_q[s]  <= nq_d;
      den_q[s] <= cur_den;
      pay_q[s] <= cur_pay;
    end
  end

  assign out_valid_o = vld_q[NW-1];
  assign out_quo_o   = nq_q[NW-1];
  assign out_pay_o   = pay_q[NW-1];

endmodule

// File: design/ray_axis_quad_intersect_unit.sv
// Ray against axis-aligned rectangle, fully pipelined.
// Input channel: a ray beat (origin, direction, t_min, t_max) is taken at a
// rising edge with start_i high and busy_o low; busy_o is always low, so one
// ray can enter every cycle.
// Result channel: done_o marks each result for one cycle; the receiver cannot
// stall, and the pipeline never holds. Results leave in input order.
// Pipeline: the t divider (COORD_WIDTH+FRAC_BITS stages), the u/v dividers
// (COORD_WIDTH+FRAC_BITS+9 stages) and six registers around them; numbers
// default to signed Q16.16.
// Throughput: one ray per cycle.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i; write
// only when no ray is in flight.
// Reset: clears all valid bits and loads the register defaults
// (z plane, corner at the origin, unit edges).
// A miss returns is_hit_o low and all other fields zero.
module ray_axis_quad_intersect_unit #(
  parameter int unsigned COORD_WIDTH = rai_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rai_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rai_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [COORD_WIDTH-1:0]        origin_x_i,
  input  logic [COORD_WIDTH-1:0]        origin_y_i,
  input  logic [COORD_WIDTH-1:0]        origin_z_i,
  input  logic [COORD_WIDTH-1:0]        dir_x_i,
  input  logic [COORD_WIDTH-1:0]        dir_y_i,
  input  logic [COORD_WIDTH-1:0]        dir_z_i,
  input  logic [COORD_WIDTH-1:0]        t_min_i,
  input  logic [COORD_WIDTH-1:0]        t_max_i,
  output logic                          done_o,
  output logic                          is_hit_o,
  output logic [COORD_WIDTH-1:0]        hit_t_o,
  output logic [COORD_WIDTH-1:0]        point_x_o,
  output logic [COORD_WIDTH-1:0]        point_y_o,
  output logic [COORD_WIDTH-1:0]        point_z_o,
  output logic [FRAC_BITS:0]            tex_u_o,
  output logic [FRAC_BITS:0]            tex_v_o,
  output logic [1:0]                    normal_axis_o
);

  import rai_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned TN  = W + F;         // t dividend magnitude
  localparam int unsigned TS  = TN + 1;        // signed t
  localparam int unsigned PTW = 2 * W + 1;     // hit point, unsaturated
  localparam int unsigned PQW = PTW + 1;       // offset from corner
  localparam int unsigned MGW = W + 9;         // bounded offset magnitude
  localparam int unsigned UN  = MGW + F;       // u/v dividend magnitude
  localparam int unsigned LAT = TN + UN + 6;

  localparam logic signed [PTW-1:0] SAT_MAX  = (PTW'(1) << (W - 1)) - PTW'(1);
  localparam logic signed [PTW-1:0] SAT_MIN  = -SAT_MAX - PTW'(1);
  localparam logic signed [PQW-1:0] PQ_BOUND = PQW'(1) << (W + 8);
  localparam logic [UN-1:0]         ONE_U    = UN'(1) << F;

  typedef struct packed {
    logic [2:0][W-1:0] org;
    logic [2:0][W-1:0] dir;
    logic [W-1:0]      tmin;
    logic [W-1:0]      tmax;
    logic              neg;
    logic              miss;
  } tray_t;

  typedef struct packed {
    logic [W-1:0]      t;
    logic [2:0][W-1:0] pt;
    logic              neg;
    logic              miss;
  } upay_t;

  localparam int unsigned TPW = $bits(tray_t);
  localparam int unsigned UPW = $bits(upay_t);

  // configuration registers
  logic [1:0]        plane_axis_q;
  logic [2:0][W-1:0] corner_q;
  logic [W-1:0]      edge_u_q;
  logic [W-1:0]      edge_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_axis_q <= AXIS_Z;
      corner_q     <= '0;
      edge_u_q     <= W'(1) << F;
      edge_v_q     <= W'(1) << F;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PLANE_AXIS: plane_axis_q <= cfg_wdata_i[1:0];
        REG_CORNER_X:   corner_q[0]  <= cfg_wdata_i;
        REG_CORNER_Y:   corner_q[1]  <= cfg_wdata_i;
        REG_CORNER_Z:   corner_q[2]  <= cfg_wdata_i;
        REG_EDGE_U:     edge_u_q     <= cfg_wdata_i;
        REG_EDGE_V:     edge_v_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // front: plane offset and direction on the plane axis
  logic [2:0][W-1:0] org_in;
  logic [2:0][W-1:0] dir_in;
  logic [W-1:0]      org_a;
  logic [W-1:0]      dir_a;
  logic [W-1:0]      cor_a;
  logic              axis_bad;

  assign org_in = {origin_z_i, origin_y_i, origin_x_i};
  assign dir_in = {dir_z_i, dir_y_i, dir_x_i};

  always_comb begin
    org_a    = org_in[0];
    dir_a    = dir_in[0];
    cor_a    = corner_q[0];
    axis_bad = 1'b0;
    case (plane_axis_q)
      AXIS_X: begin
        org_a = org_in[0];
        dir_a = dir_in[0];
        cor_a = corner_q[0];
      end
      AXIS_Y: begin
        org_a = org_in[1];
        dir_a = dir_in[1];
        cor_a = corner_q[1];
      end
      AXIS_Z: begin
        org_a = org_in[2];
        dir_a = dir_in[2];
        cor_a = corner_q[2];
      end
      default: axis_bad = 1'b1;
    endcase
  end

  logic              s1_vld_q;
  logic signed [W:0] s1_num_q;
  logic [W-1:0]      s1_dira_q;
  tray_t             s1_ray_q;
  tray_t             s1_ray_d;

  always_comb begin
    s1_ray_d      = '0;
    s1_ray_d.org  = org_in;
    s1_ray_d.dir  = dir_in;
    s1_ray_d.tmin = t_min_i;
    s1_ray_d.tmax = t_max_i;
    s1_ray_d.miss = axis_bad || (dir_a == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q  <= $signed({cor_a[W-1], cor_a}) - $signed({org_a[W-1], org_a});
    s1_dira_q <= dir_a;
    s1_ray_q  <= s1_ray_d;
  end

  // t divider operands
  logic [W:0]    num_abs;
  logic [W-1:0]  dir_abs;
  logic [TN-1:0] t_dividend;
  tray_t         t_pay;

  assign num_abs    = s1_num_q[W] ? (W+1)'(-s1_num_q) : s1_num_q;
  assign dir_abs    = s1_dira_q[W-1] ? (-s1_dira_q) : s1_dira_q;
  assign t_dividend = {num_abs[W-1:0], {F{1'b0}}};

  always_comb begin
    t_pay     = s1_ray_q;
    t_pay.neg = s1_num_q[W] ^ s1_dira_q[W-1];
  end

  logic          td_vld;
  logic [TN-1:0] td_quo;
  logic [TPW-1:0] td_pay_raw;
  tray_t         td_pay;

  rai_div #(
    .NW (TN),
    .DW (W),
    .PW (TPW)
  ) u_div_t (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_vld_q),
    .in_num_i    (t_dividend),
    .in_den_i    (dir_abs),
    .in_pay_i    (t_pay),
    .out_valid_o (td_vld),
    .out_quo_o   (td_quo),
    .out_pay_o   (td_pay_raw)
  );

  assign td_pay = tray_t'(td_pay_raw);

  // interval test on the full quotient
  logic signed [TS-1:0] t_pos;
  logic signed [TS-1:0] t_full;
  logic signed [TS-1:0] tmin_ext;
  logic signed [TS-1:0] tmax_ext;
  logic                 t_out;

  assign t_pos    = $signed({1'b0, td_quo});
  assign t_full   = td_pay.neg ? -t_pos : t_pos;
  assign tmin_ext = $signed({{(F+1){td_pay.tmin[W-1]}}, td_pay.tmin});
  assign tmax_ext = $signed({{(F+1){td_pay.tmax[W-1]}}, td_pay.tmax});
  assign t_out    = (t_full < tmin_ext) || (t_full > tmax_ext);

  logic              c_vld_q;
  logic [W-1:0]      c_t_q;
  logic [2:0][W-1:0] c_org_q;
  logic [2:0][W-1:0] c_dir_q;
  logic              c_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= td_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_t_q    <= t_full[W-1:0];
    c_org_q  <= td_pay.org;
    c_dir_q  <= td_pay.dir;
    c_miss_q <= td_pay.miss || t_out;
  end

  // direction times t, one multiplier per axis
  logic                     m_vld_q;
  logic signed [2*W-1:0]    m_prod_q [3];
  logic [2:0][W-1:0]        m_org_q;
  logic [W-1:0]             m_t_q;
  logic                     m_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      m_prod_q[k] <= $signed(c_dir_q[k]) * $signed(c_t_q);
    end
    m_org_q  <= c_org_q;
    m_t_q    <= c_t_q;
    m_miss_q <= c_miss_q;
  end

  // hit point, floor of the scaled product plus origin
  logic signed [2*W-1:0] m_shift [3];
  logic signed [PTW-1:0] p_pt_d  [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign m_shift[k] = m_prod_q[k] >>> F;
    assign p_pt_d[k]  = $signed({{(W+1){m_org_q[k][W-1]}}, m_org_q[k]})
                      + $signed({m_shift[k][2*W-1], m_shift[k]});
  end

  logic                  p_vld_q;
  logic signed [PTW-1:0] p_pt_q [3];
  logic [W-1:0]          p_t_q;
  logic                  p_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p_pt_q[k] <= p_pt_d[k];
    end
    p_t_q    <= m_t_q;
    p_miss_q <= m_miss_q;
  end

  // offsets from the corner on the two in-plane axes
  logic signed [PTW-1:0] pt_u;
  logic signed [PTW-1:0] pt_v;
  logic [W-1:0]          cor_u;
  logic [W-1:0]          cor_v;

  always_comb begin
    case (plane_axis_q)
      AXIS_X: begin
        pt_u  = p_pt_q[1];
        cor_u = corner_q[1];
        pt_v  = p_pt_q[2];
        cor_v = corner_q[2];
      end
      AXIS_Y: begin
        pt_u  = p_pt_q[2];
        cor_u = corner_q[2];
        pt_v  = p_pt_q[0];
        cor_v = corner_q[0];
      end
      AXIS_Z: begin
        pt_u  = p_pt_q[0];
        cor_u = corner_q[0];
        pt_v  = p_pt_q[1];
        cor_v = corner_q[1];
      end
      default: begin
        pt_u  = p_pt_q[0];
        cor_u = corner_q[0];
        pt_v  = p_pt_q[1];
        cor_v = corner_q[1];
      end
    endcase
  end

  logic signed [PQW-1:0] pq_u;
  logic signed [PQW-1:0] pq_v;
  logic [PQW-1:0]        pq_u_abs;
  logic [PQW-1:0]        pq_v_abs;
  logic                  far_u;
  logic                  far_v;
  logic [2:0][W-1:0]     pt_sat;

  assign pq_u = $signed({pt_u[PTW-1], pt_u}) - $signed({{(W+2){cor_u[W-1]}}, cor_u});
  assign pq_v = $signed({pt_v[PTW-1], pt_v}) - $signed({{(W+2){cor_v[W-1]}}, cor_v});
  assign pq_u_abs = pq_u[PQW-1] ? (-pq_u) : pq_u;
  assign pq_v_abs = pq_v[PQW-1] ? (-pq_v) : pq_v;
  assign far_u    = (pq_u > PQ_BOUND) || (pq_u < -PQ_BOUND);
  assign far_v    = (pq_v > PQ_BOUND) || (pq_v < -PQ_BOUND);

  // saturate the point to the coordinate range
  for (genvar k = 0; k < 3; k++) begin : g_sat
    always_comb begin
      if (p_pt_q[k] > SAT_MAX) begin
        pt_sat[k] = SAT_MAX[W-1:0];
      end else if (p_pt_q[k] < SAT_MIN) begin
        pt_sat[k] = SAT_MIN[W-1:0];
      end else begin
        pt_sat[k] = p_pt_q[k][W-1:0];
      end
    end
  end

  logic          q_vld_q;
  logic [UN-1:0] q_num_u_q;
  logic [UN-1:0] q_num_v_q;
  logic          q_neg_v_q;
  upay_t         q_pay_q;
  upay_t         q_pay_d;

  always_comb begin
    q_pay_d      = '0;
    q_pay_d.t    = p_t_q;
    q_pay_d.pt   = pt_sat;
    q_pay_d.neg  = pq_u[PQW-1] ^ edge_u_q[W-1];
    q_pay_d.miss = p_miss_q || far_u || far_v || (edge_u_q == '0) || (edge_v_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else begin
      q_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_num_u_q <= {pq_u_abs[MGW-1:0], {F{1'b0}}};
    q_num_v_q <= {pq_v_abs[MGW-1:0], {F{1'b0}}};
    q_neg_v_q <= pq_v[PQW-1] ^ edge_v_q[W-1];
    q_pay_q   <= q_pay_d;
  end

  // u and v dividers run in lockstep
  logic [W-1:0] edge_u_abs;
  logic [W-1:0] edge_v_abs;

  assign edge_u_abs = edge_u_q[W-1] ? (-edge_u_q) : edge_u_q;
  assign edge_v_abs = edge_v_q[W-1] ? (-edge_v_q) : edge_v_q;

  logic           ud_vld;
  logic [UN-1:0]  ud_quo;
  logic [UPW-1:0] ud_pay_raw;
  upay_t          ud_pay;
  logic           vd_vld;
  logic [UN-1:0]  vd_quo;
  logic           vd_neg;

  rai_div #(
    .NW (UN),
    .DW (W),
    .PW (UPW)
  ) u_div_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_vld_q),
    .in_num_i    (q_num_u_q),
    .in_den_i    (edge_u_abs),
    .in_pay_i    (q_pay_q),
    .out_valid_o (ud_vld),
    .out_quo_o   (ud_quo),
    .out_pay_o   (ud_pay_raw)
  );

  rai_div #(
    .NW (UN),
    .DW (W),
    .PW (1)
  ) u_div_v (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_vld_q),
    .in_num_i    (q_num_v_q),
    .in_den_i    (edge_v_abs),
    .in_pay_i    (q_neg_v_q),
    .out_valid_o (vd_vld),
    .out_quo_o   (vd_quo),
    .out_pay_o   (vd_neg)
  );

  assign ud_pay = upay_t'(ud_pay_raw);

  // plane coordinates in [0,1]; a quotient truncated to zero is inside
  logic u_in;
  logic v_in;
  logic hit;

  assign u_in = (ud_quo == '0) || (!ud_pay.neg && (ud_quo <= ONE_U));
  assign v_in = (vd_quo == '0) || (!vd_neg && (vd_quo <= ONE_U));
  assign hit  = !ud_pay.miss && u_in && v_in;

  // result register, zeroed on a miss
  logic          done_q;
  logic          hit_q;
  logic [W-1:0]  hit_t_q;
  logic [2:0][W-1:0] point_q;
  logic [F:0]    tex_u_q;
  logic [F:0]    tex_v_q;
  logic [1:0]    normal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ud_vld && vd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit;
    hit_t_q  <= hit ? ud_pay.t : '0;
    point_q  <= hit ? ud_pay.pt : '0;
    tex_u_q  <= hit ? ud_quo[F:0] : '0;
    tex_v_q  <= hit ? vd_quo[F:0] : '0;
    normal_q <= hit ? plane_axis_q : 2'b00;
  end

  assign done_o        = done_q;
  assign is_hit_o      = done_q && hit_q;
  assign hit_t_o       = hit_t_q;
  assign point_x_o     = point_q[0];
  assign point_y_o     = point_q[1];
  assign point_z_o     = point_q[2];
  assign tex_u_o       = tex_u_q;
  assign tex_v_o       = tex_v_q;
  assign normal_axis_o = normal_q;

  // fixed latency from accepted ray to result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing after pipeline latency");

  // u and v dividers stay aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ud_vld == vd_vld)
    else $error("u and v dividers out of step");

  // a miss reports all fields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_hit_o) |-> (hit_t_o == '0 && point_x_o == '0 && point_y_o == '0
      && point_z_o == '0 && tex_u_o == '0 && tex_v_o == '0 && normal_axis_o == 2'b00))
    else $error("miss with nonzero fields");

  // a hit has a real axis and plane coordinates within one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_hit_o |-> (normal_axis_o != 2'b11 && tex_u_o <= ONE_U[F:0] && tex_v_o <= ONE_U[F:0]))
    else $error("hit with bad axis or coordinate");

endmodule

// File: sim/ray_axis_quad_intersect_checker.sv
`timescale 1ns / 1ps

module ray_axis_quad_intersect_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rai_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [31:0]                   origin_x_i,
  input  logic [31:0]                   origin_y_i,
  input  logic [31:0]                   origin_z_i,
  input  logic [31:0]                   dir_x_i,
  input  logic [31:0]                   dir_y_i,
  input  logic [31:0]                   dir_z_i,
  input  logic [31:0]                   t_min_i,
  input  logic [31:0]                   t_max_i,
  input  logic                          done_i,
  input  logic                          is_hit_i,
  input  logic [31:0]                   hit_t_i,
  input  logic [31:0]                   point_x_i,
  input  logic [31:0]                   point_y_i,
  input  logic [31:0]                   point_z_i,
  input  logic [16:0]                   tex_u_i,
  input  logic [16:0]                   tex_v_i,
  input  logic [1:0]                    normal_axis_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import rai_pkg::*;

  localparam int    FB       = 16;
  localparam longint ONE     = 64'sd65536;
  localparam longint PQ_LIM  = 64'sd1 << 40;
  localparam longint CMAX    = 64'sd2147483647;
  localparam longint CMIN    = -64'sd2147483648;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] u;
    logic [16:0] v;
    logic [1:0]  n;
  } rect_hit_t;

  // shadow of the rectangle registers
  logic [1:0] axis_q;
  longint     corner_q [3];
  longint     edge_u_q;
  longint     edge_v_q;

  rect_hit_t  hit_results_q [$];

  function automatic logic [31:0] clamp32(input longint x);
    if (x > CMAX) return CMAX[31:0];
    if (x < CMIN) return CMIN[31:0];
    return x[31:0];
  endfunction

  // plane coordinate with range rejection
  function automatic bit uv_coord(input longint pq, input longint edge_len,
                                  output longint q);
    q = 0;
    if (edge_len == 0) return 0;
    if (pq > PQ_LIM || pq < -PQ_LIM) return 0;
    q = (pq * ONE) / edge_len;
    if (q < 0 || q > ONE) return 0;
    return 1;
  endfunction

  function automatic rect_hit_t trace_rect(
    input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
    input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
    input logic [31:0] tlo, input logic [31:0] thi);
    longint    org [3];
    longint    dv [3];
    longint    pt [3];
    longint    tmin, tmax, num, t, u, v;
    int        a, ua, va;
    rect_hit_t r;
    r = '0;
    org[0] = longint'($signed(ox));
    org[1] = longint'($signed(oy));
    org[2] = longint'($signed(oz));
    dv[0]  = longint'($signed(dx));
    dv[1]  = longint'($signed(dy));
    dv[2]  = longint'($signed(dz));
    tmin   = longint'($signed(tlo));
    tmax   = longint'($signed(thi));
    if (axis_q > AXIS_Z) return r;
    a = int'(axis_q);
    if (dv[a] == 0) return r;
    num = corner_q[a] - org[a];
    t = (num * ONE) / dv[a];
    if (t < tmin || t > tmax) return r;
    for (int k = 0; k < 3; k++) pt[k] = org[k] + ((dv[k] * t) >>> FB);
    ua = (a + 1) % 3;
    va = (a + 2) % 3;
    if (!uv_coord(pt[ua] - corner_q[ua], edge_u_q, u)) return r;
    if (!uv_coord(pt[va] - corner_q[va], edge_v_q, v)) return r;
    r.hit = 1'b1;
    r.t   = t[31:0];
    r.px  = clamp32(pt[0]);
    r.py  = clamp32(pt[1]);
    r.pz  = clamp32(pt[2]);
    r.u   = u[16:0];
    r.v   = v[16:0];
    r.n   = a[1:0];
    return r;
  endfunction

  // watch config writes, ray beats and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    rect_hit_t want, got;
    if (!rst_ni) begin
      axis_q      <= AXIS_Z;
      corner_q[0] <= 0;
      corner_q[1] <= 0;
      corner_q[2] <= 0;
      edge_u_q    <= ONE;
      edge_v_q    <= ONE;
      hit_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_i) begin
        got = '{is_hit_i, hit_t_i, point_x_i, point_y_i, point_z_i,
                tex_u_i, tex_v_i, normal_axis_i};
        if (hit_results_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = hit_results_q.pop_front();
          if (got.hit !== want.hit || got.t !== want.t || got.px !== want.px ||
              got.py !== want.py || got.pz !== want.pz || got.u !== want.u ||
              got.v !== want.v || got.n !== want.n) begin
            if (fail_count_o < 10) begin
              $display("result mismatch: expected %p", want);
              $display("                 actual   %p", got);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        hit_results_q.push_back(trace_rect(origin_x_i, origin_y_i, origin_z_i,
                                           dir_x_i, dir_y_i, dir_z_i,
                                           t_min_i, t_max_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PLANE_AXIS: axis_q      <= cfg_wdata_i[1:0];
          REG_CORNER_X:   corner_q[0] <= longint'($signed(cfg_wdata_i));
          REG_CORNER_Y:   corner_q[1] <= longint'($signed(cfg_wdata_i));
          REG_CORNER_Z:   corner_q[2] <= longint'($signed(cfg_wdata_i));
          REG_EDGE_U:     edge_u_q    <= longint'($signed(cfg_wdata_i));
          REG_EDGE_V:     edge_v_q    <= longint'($signed(cfg_wdata_i));
          default: ;
        endcase
      end
      pending_o <= hit_results_q.size();
    end
  end

endmodule

// File: sim/ray_axis_quad_intersect_unit_tb.sv
`timescale 1ns / 1ps

module ray_axis_quad_intersect_unit_tb;
  import rai_pkg::*;

  localparam logic [31:0] ONE_Q    = 32'h0001_0000;
  localparam logic [31:0] MAX_Q    = 32'h7fff_ffff;
  localparam logic [31:0] MIN_Q    = 32'h8000_0000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 130;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic [31:0]          origin_x_i, origin_y_i, origin_z_i;
  logic [31:0]          dir_x_i, dir_y_i, dir_z_i;
  logic [31:0]          t_min_i, t_max_i;
  logic                 done_o;
  logic                 is_hit_o;
  logic [31:0]          hit_t_o, point_x_o, point_y_o, point_z_o;
  logic [16:0]          tex_u_o, tex_v_o;
  logic [1:0]           normal_axis_o;
  int                   fail_count;
  int                   pending;

  // current rectangle, mirrored for building hitting rays
  logic [1:0] rect_axis;
  longint     rect_corner [3];
  longint     rect_eu, rect_ev;
  int         burst_left;

  ray_axis_quad_intersect_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .t_min_i, .t_max_i, .done_o, .is_hit_o, .hit_t_o, .point_x_o, .point_y_o,
    .point_z_o, .tex_u_o, .tex_v_o, .normal_axis_o
  );

  ray_axis_quad_intersect_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i,
    .busy_i(busy_o), .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i,
    .dir_y_i, .dir_z_i, .t_min_i, .t_max_i, .done_i(done_o), .is_hit_i(is_hit_o),
    .hit_t_i(hit_t_o), .point_x_i(point_x_o), .point_y_i(point_y_o),
    .point_z_i(point_z_o), .tex_u_i(tex_u_o), .tex_v_i(tex_v_o),
    .normal_axis_i(normal_axis_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("ray_axis_quad_intersect_unit verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_rect(input logic [1:0] ax, input logic [31:0] cx,
                          input logic [31:0] cy, input logic [31:0] cz,
                          input logic [31:0] eu, input logic [31:0] ev);
    write_reg(REG_PLANE_AXIS, {30'd0, ax});
    write_reg(REG_CORNER_X, cx);
    write_reg(REG_CORNER_Y, cy);
    write_reg(REG_CORNER_Z, cz);
    write_reg(REG_EDGE_U, eu);
    write_reg(REG_EDGE_V, ev);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    rect_axis      = ax;
    rect_corner[0] = longint'($signed(cx));
    rect_corner[1] = longint'($signed(cy));
    rect_corner[2] = longint'($signed(cz));
    rect_eu        = longint'($signed(eu));
    rect_ev        = longint'($signed(ev));
  endtask

  // one ray beat, held until taken
  task automatic send_ray(input logic [31:0] f [8]);
    start_i    <= 1'b1;
    origin_x_i <= f[0];
    origin_y_i <= f[1];
    origin_z_i <= f[2];
    dir_x_i    <= f[3];
    dir_y_i    <= f[4];
    dir_z_i    <= f[5];
    t_min_i    <= f[6];
    t_max_i    <= f[7];
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic ray8(input logic [31:0] ox, input logic [31:0] oy,
                      input logic [31:0] oz, input logic [31:0] dx,
                      input logic [31:0] dy, input logic [31:0] dz,
                      input logic [31:0] tlo, input logic [31:0] thi);
    logic [31:0] f [8];
    f = '{ox, oy, oz, dx, dy, dz, tlo, thi};
    send_ray(f);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ray aimed at a random point of the rectangle
  task automatic aimed_ray(output logic [31:0] f [8]);
    longint tgt [3];
    longint dv [3];
    longint t;
    int     a, ua, va;
    a  = (rect_axis > AXIS_Z) ? $urandom_range(0, 2) : int'(rect_axis);
    ua = (a + 1) % 3;
    va = (a + 2) % 3;
    tgt[a]  = rect_corner[a];
    tgt[ua] = rect_corner[ua] + ((longint'($urandom_range(0, 65536)) * rect_eu) >>> 16);
    tgt[va] = rect_corner[va] + ((longint'($urandom_range(0, 65536)) * rect_ev) >>> 16);
    for (int k = 0; k < 3; k++) dv[k] = longint'($urandom_range(0, 262143)) - 131072;
    if (dv[a] == 0) dv[a] = 4096;
    t = longint'($urandom_range(0, 1 << 20)) - 4096;
    for (int k = 0; k < 3; k++) begin
      f[k]     = 32'(tgt[k] - ((dv[k] * t) >>> 16));
      f[3 + k] = dv[k][31:0];
    end
    f[6] = 32'(t - longint'($urandom_range(0, 65536)));
    f[7] = 32'(t + longint'($urandom_range(0, 65536)));
  endtask

  // mix of aimed, broken and noise rays, sent in bursts
  task automatic random_rays(input int count);
    logic [31:0] f [8];
    int          kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        for (int k = 0; k < 8; k++) f[k] = $urandom;
      end else begin
        aimed_ray(f);
        if (kind < 30) f[$urandom_range(0, 7)] ^= 32'd1 << $urandom_range(0, 31);
        else if (kind < 36) f[6] = f[7] + 32'd1;
      end
      if (burst_left == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      send_ray(f);
    end
    drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_PLANE_AXIS;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    origin_x_i  <= '0;
    origin_y_i  <= '0;
    origin_z_i  <= '0;
    dir_x_i     <= '0;
    dir_y_i     <= '0;
    dir_z_i     <= '0;
    t_min_i     <= '0;
    t_max_i     <= '0;
    rect_axis      = AXIS_Z;
    rect_corner[0] = 0;
    rect_corner[1] = 0;
    rect_corner[2] = 0;
    rect_eu        = 65536;
    rect_ev        = 65536;
    burst_left     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rays against the reset rectangle
    ray8(32'h8000, 32'h8000, -ONE_Q, 0, 0, ONE_Q, 0, 2 * ONE_Q);
    ray8(32'h8000, 32'h8000, -ONE_Q, ONE_Q, 0, 0, 0, 2 * ONE_Q);
    ray8(32'h8000, 32'h8000, -ONE_Q, 0, 0, ONE_Q, 2 * ONE_Q, 0);
    ray8(32'h8000, 32'h8000, -ONE_Q, 0, 0, ONE_Q, ONE_Q, ONE_Q);
    ray8(ONE_Q, ONE_Q, -ONE_Q, 0, 0, ONE_Q, 0, 2 * ONE_Q);
    ray8(ONE_Q + 1, 32'h8000, -ONE_Q, 0, 0, ONE_Q, 0, 2 * ONE_Q);
    ray8(32'h4000, 32'h4000, ONE_Q, 0, 0, -ONE_Q, 0, 2 * ONE_Q);
    ray8(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    ray8(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    ray8(0, 0, 32'hc000_0000, MAX_Q, 0, ONE_Q, 0, MAX_Q);
    ray8(32'h4000, 32'h4000, ONE_Q, 0, 0, ONE_Q, MIN_Q, 0);
    ray8(0, 0, -ONE_Q, 0, 0, ONE_Q, 0, MAX_Q);
    ray8(32'h8000, 32'h8000, -ONE_Q, 32'h100, 32'h200, 1, 0, MAX_Q);
    drain();
    random_rays(50);

    // doubled edges: tiny negative coordinate truncates to zero
    set_rect(AXIS_Z, 0, 0, 0, 2 * ONE_Q, 2 * ONE_Q);
    ray8(32'hffff_ffff, 32'h8000, -ONE_Q, 0, 0, ONE_Q, 0, 2 * ONE_Q);
    ray8(32'h8000, 32'hffff_ffff, -ONE_Q, 0, 0, ONE_Q, 0, 2 * ONE_Q);
    drain();
    random_rays(50);

    set_rect(AXIS_X, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, ONE_Q, 32'h0004_0000);
    random_rays(50);
    set_rect(AXIS_Y, 32'hfff0_0000, 32'h0001_2345, 32'h0002_0000,
             -2 * ONE_Q, -ONE_Q);
    random_rays(50);

    // axis value three: every ray misses
    set_rect(2'd3, 0, 0, 0, ONE_Q, ONE_Q);
    random_rays(50);

    // zero edge lengths
    set_rect(AXIS_X, 0, 0, 0, 0, ONE_Q);
    random_rays(25);
    set_rect(AXIS_Y, 0, 0, 0, ONE_Q, 0);
    random_rays(25);

    // extreme corners and edges
    set_rect(AXIS_Z, MAX_Q, MIN_Q, MAX_Q, MAX_Q, MIN_Q);
    random_rays(25);
    set_rect(AXIS_X, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q);
    random_rays(25);

    // spare indexes are ignored by the block
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    set_rect(AXIS_Y, 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000,
             32'($urandom_range(0, 1 << 20)), 32'hffff_0000,
             32'($urandom_range(1, 1 << 19)), 32'($urandom_range(1, 1 << 19)));
    random_rays(50);

    if (fail_count == 0 && pending == 0) begin
      $display("ray_axis_quad_intersect_unit verification clean");
    end else begin
      $display("ray_axis_quad_intersect_unit verification failed");
    end
    $finish;
  end

endmodule
